>>> sv/cco_pkg.sv
package cco_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_FRAC_BITS_DEF = 8;
   localparam int CORDIC_ITERS_DEF = 16;

   // Fixed field widths and structure sizes.
   localparam int TAB_LEN = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int COORD_W = 24;
   localparam int RAD_W = 23;
   localparam int CNT_W = 7;
   localparam int CAP_W = 6;
   localparam int ANG_W = 32;

   typedef struct packed {
      logic                      req_type;
      logic signed [COORD_W-1:0] center1_x;
      logic signed [COORD_W-1:0] center1_y;
      logic signed [COORD_W-1:0] center2_x;
      logic signed [COORD_W-1:0] center2_y;
      logic        [RAD_W-1:0]   radius;
      logic        [CNT_W-1:0]   segments;
   } cco_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] from_x;
      logic signed [COORD_W-1:0] from_y;
      logic signed [COORD_W-1:0] to_x;
      logic signed [COORD_W-1:0] to_y;
      logic                      last;
   } cco_rsp_type;

   // One classified shape, handed from the front end to the point generator.
   typedef struct packed {
      logic                      circle;
      logic        [CNT_W-1:0]   count;
      logic        [CAP_W-1:0]   cap;
      logic        [ANG_W-1:0]   axis;
      logic signed [COORD_W-1:0] c1x;
      logic signed [COORD_W-1:0] c1y;
      logic signed [COORD_W-1:0] c2x;
      logic signed [COORD_W-1:0] c2y;
      logic        [RAD_W-1:0]   radius;
   } cco_job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_VEC,
      F_PUSH
   } cco_front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SETUP,
      B_DIV,
      B_RINIT,
      B_ROT,
      B_MUL,
      B_SUM,
      B_POINT
   } cco_back_state_type;

   // Arctangent of 2^-i as a binary angle, one full turn = 2^32.
   function automatic logic [ANG_W-1:0] atan_at(input logic [4:0] idx);
      logic [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Inverse CORDIC gain in Q30, evaluated at elaboration time only.
   function automatic logic [63:0] inv_gain_q30(input int iters);
      logic [63:0] p;
      logic [63:0] t;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] numer;
      logic [63:0] q;
      logic [63:0] rem;
      p = 64'd1 << 30;
      for (int i = 0; i < iters; i++) begin
         t = (2 * i <= 30) ? (64'd1 << (30 - 2 * i)) : 64'd0;
         p = (p * ((64'd1 << 30) + t) + (64'd1 << 29)) >> 30;
      end
      // Integer square root of p * 2^30.
      v = p << 30;
      r = '0;
      b = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (b > v) b = b >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      // Rounded 2^60 / root by restoring long division.
      numer = (64'd1 << 60) + (r >> 1);
      q = '0;
      rem = '0;
      for (int j = 63; j >= 0; j--) begin
         rem = {rem[62:0], numer[j]};
         if (rem >= r) begin
            rem = rem - r;
            q[j] = 1'b1;
         end
      end
      return q;
   endfunction

endpackage

>>> sv/circle_capsule_outline_generator.sv
// Each outline point passes a 40-step angle divider, one rotation step a cycle, a
// multiply and a round; a capsule's axis angle is first found by the front end.
// Points go out as segments, stalling while the result queue is full; a closing
// segment wraps back to the first point, and the back end then fetches the next shape.
// The front end finds the next capsule axis while the back end draws the current shape.
// Reset is synchronous and active high; it empties both queues and idles both ends.
module circle_capsule_outline_generator #(
   parameter int MAX_POINTS = cco_pkg::MAX_POINTS_DEF,
   parameter int COORD_FRAC_BITS = cco_pkg::COORD_FRAC_BITS_DEF,
   parameter int CORDIC_ITERS = cco_pkg::CORDIC_ITERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  cco_pkg::cco_req_type req_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output cco_pkg::cco_rsp_type rsp_item
);

   logic                 job_push;
   logic                 job_full;
   logic                 job_pop;
   logic                 job_empty;
   cco_pkg::cco_job_type job_in;
   cco_pkg::cco_job_type job_out;
   logic                 seg_push;
   logic                 seg_full;
   cco_pkg::cco_rsp_type seg_item;

   // Request classification and capsule axis.
   cco_front #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .CORDIC_ITERS(CORDIC_ITERS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_item(req_item),
      .job_full(job_full),
      .job_push(job_push),
      .job_item(job_in)
   );

   // Shape queue between the two ends.
   cco_queue #(
      .T(cco_pkg::cco_job_type),
      .DEPTH(cco_pkg::QUEUE_DEPTH)
   ) u_job_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data(job_in),
      .full(job_full),
      .pop(job_pop),
      .pop_data(job_out),
      .empty(job_empty)
   );

   // Point generation and segment output.
   cco_back #(
      .MAX_POINTS(MAX_POINTS),
      .CORDIC_ITERS(CORDIC_ITERS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_empty(job_empty),
      .job_pop(job_pop),
      .job_item(job_out),
      .seg_full(seg_full),
      .seg_push(seg_push),
      .seg_item(seg_item)
   );

   // Result queue toward the consumer.
   cco_queue #(
      .T(cco_pkg::cco_rsp_type),
      .DEPTH(cco_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(seg_push),
      .push_data(seg_item),
      .full(seg_full),
      .pop(rsp_pop),
      .pop_data(rsp_item),
      .empty(rsp_empty)
   );

`ifndef SYNTHESIS
   a_job_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(job_push && job_full)) else $error("Shape pushed into a full queue.");
   a_seg_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(seg_push && seg_full)) else $error("Segment pushed into a full queue.");
   a_pop_with_close: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (seg_push && seg_item.last)) else $error("Shape retired without closing.");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty) else $error("Results pending after reset.");
`endif

endmodule

>>> sv/cco_queue.sv
module cco_queue #(
   parameter type T = logic,
   parameter int DEPTH = cco_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_data,
   output logic full,
   input  logic pop,
   output T     pop_data,
   output logic empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   T              mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push;
   logic          do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/cco_front.sv
module cco_front #(
   parameter int MAX_POINTS = cco_pkg::MAX_POINTS_DEF,
   parameter int COORD_FRAC_BITS = cco_pkg::COORD_FRAC_BITS_DEF,
   parameter int CORDIC_ITERS = cco_pkg::CORDIC_ITERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  cco_pkg::cco_req_type req_item,
   input  logic                 job_full,
   output logic                 job_push,
   output cco_pkg::cco_job_type job_item
);

   localparam int ITERS_EFF = (CORDIC_ITERS > cco_pkg::TAB_LEN) ? cco_pkg::TAB_LEN
                                                                 : CORDIC_ITERS;
   localparam logic [63:0] DEGEN_THR =
      ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd99999999) / 64'd100000000;
   localparam logic [cco_pkg::CNT_W-1:0] MAXP = cco_pkg::CNT_W'(MAX_POINTS);
   localparam logic [cco_pkg::CNT_W-1:0] MAXC = cco_pkg::CNT_W'(MAX_POINTS / 2);

   cco_pkg::cco_front_state_type state_ff;
   cco_pkg::cco_front_state_type state_in;
   cco_pkg::cco_job_type         job_ff;
   logic signed [47:0]           vx_ff;
   logic signed [47:0]           vy_ff;
   logic signed [33:0]           vz_ff;
   logic [cco_pkg::ANG_W-1:0]    base_ff;
   logic [4:0]                   it_ff;

   logic                          accept;
   logic signed [25:0]            dx;
   logic signed [25:0]            dy;
   logic signed [25:0]            dxn;
   logic signed [25:0]            dyn;
   logic [25:0]                   ax;
   logic [25:0]                   ay;
   logic [6:0]                    d2;
   logic                          degen;
   logic                          emits;
   logic                          is_circle;
   logic [cco_pkg::CNT_W-1:0]     cap;
   logic [cco_pkg::CNT_W-1:0]     count;
   logic                          last_iter;

   assign accept = (state_ff == cco_pkg::F_IDLE) && req_push;

   // Request classification: point counts and coinciding centres.
   always_comb begin
      dx = 26'(req_item.center2_x) - 26'(req_item.center1_x);
      dy = 26'(req_item.center2_y) - 26'(req_item.center1_y);
      ax = dx[25] ? 26'(-dx) : 26'(dx);
      ay = dy[25] ? 26'(-dy) : 26'(dy);
      d2 = 7'({4'b0, ax[2:0]} * {4'b0, ax[2:0]}) + 7'({4'b0, ay[2:0]} * {4'b0, ay[2:0]});
      degen = (ax < 26'd8) && (ay < 26'd8) && ({57'b0, d2} < DEGEN_THR);
      cap = (req_item.segments > MAXC) ? MAXC : req_item.segments;
      if (req_item.req_type) begin
         emits = (req_item.segments >= 7'd2);
         count = {cap[cco_pkg::CNT_W-2:0], 1'b0};
      end else begin
         emits = (req_item.segments >= 7'd3);
         count = (req_item.segments > MAXP) ? MAXP : req_item.segments;
      end
      is_circle = !req_item.req_type || degen;
      dxn = dx[25] ? -dx : dx;
      dyn = dx[25] ? -dy : dy;
   end

   assign last_iter = (it_ff == 5'(ITERS_EFF - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cco_pkg::F_IDLE: begin
            if (req_push && emits) begin
               state_in = is_circle ? cco_pkg::F_PUSH : cco_pkg::F_VEC;
            end
         end
         cco_pkg::F_VEC: begin
            if (last_iter) state_in = cco_pkg::F_PUSH;
         end
         cco_pkg::F_PUSH: begin
            if (!job_full) state_in = cco_pkg::F_IDLE;
         end
         default: state_in = cco_pkg::F_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_full = (state_ff != cco_pkg::F_IDLE);
      job_push = (state_ff == cco_pkg::F_PUSH) && !job_full;
      job_item = job_ff;
      job_item.axis = job_ff.circle ? '0 : base_ff + vz_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cco_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request and run the vectoring CORDIC for the capsule axis.
   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff.circle <= is_circle;
         job_ff.count <= count;
         job_ff.cap <= cap[cco_pkg::CAP_W-1:0];
         job_ff.axis <= '0;
         job_ff.c1x <= req_item.center1_x;
         job_ff.c1y <= req_item.center1_y;
         job_ff.c2x <= req_item.center2_x;
         job_ff.c2y <= req_item.center2_y;
         job_ff.radius <= req_item.radius;
         vx_ff <= 48'(dxn) <<< 20;
         vy_ff <= 48'(dyn) <<< 20;
         vz_ff <= '0;
         base_ff <= dx[25] ? 32'h80000000 : 32'h0;
         it_ff <= '0;
      end else if (state_ff == cco_pkg::F_VEC) begin
         if (vy_ff > 0) begin
            vx_ff <= vx_ff + (vy_ff >>> it_ff);
            vy_ff <= vy_ff - (vx_ff >>> it_ff);
            vz_ff <= vz_ff + $signed({2'b0, cco_pkg::atan_at(it_ff)});
         end else begin
            vx_ff <= vx_ff - (vy_ff >>> it_ff);
            vy_ff <= vy_ff + (vx_ff >>> it_ff);
            vz_ff <= vz_ff - $signed({2'b0, cco_pkg::atan_at(it_ff)});
         end
         it_ff <= it_ff + 1'b1;
      end
   end

endmodule

>>> sv/cco_back.sv
module cco_back #(
   parameter int MAX_POINTS = cco_pkg::MAX_POINTS_DEF,
   parameter int CORDIC_ITERS = cco_pkg::CORDIC_ITERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_empty,
   output logic                 job_pop,
   input  cco_pkg::cco_job_type job_item,
   input  logic                 seg_full,
   output logic                 seg_push,
   output cco_pkg::cco_rsp_type seg_item
);

   localparam int ITERS_EFF = (CORDIC_ITERS > cco_pkg::TAB_LEN) ? cco_pkg::TAB_LEN
                                                                 : CORDIC_ITERS;
   localparam logic [63:0] K_Q30 = cco_pkg::inv_gain_q30(ITERS_EFF);
   localparam int DIV_STEPS = 40;
   localparam logic signed [57:0] HALF = 58'sd536870912;
   localparam logic signed [26:0] C_MAX = 27'sd8388607;
   localparam logic signed [26:0] C_MIN = -27'sd8388608;
   localparam logic [cco_pkg::CNT_W-1:0] MAXP = cco_pkg::CNT_W'(MAX_POINTS);

   cco_pkg::cco_back_state_type  state_ff;
   cco_pkg::cco_back_state_type  state_in;
   logic [cco_pkg::CNT_W-1:0]    k_ff;
   logic                         closing_ff;
   logic [39:0]                  num_ff;
   logic [7:0]                   den_ff;
   logic [8:0]                   rem_ff;
   logic [31:0]                  quo_ff;
   logic [5:0]                   step_ff;
   logic signed [33:0]           x_ff;
   logic signed [33:0]           y_ff;
   logic signed [33:0]           z_ff;
   logic [1:0]                   quad_ff;
   logic [4:0]                   it_ff;
   logic signed [23:0]           cx_ff;
   logic signed [23:0]           cy_ff;
   logic signed [57:0]           prod_x_ff;
   logic signed [57:0]           prod_y_ff;
   logic signed [23:0]           px_ff;
   logic signed [23:0]           py_ff;
   logic signed [23:0]           first_x_ff;
   logic signed [23:0]           first_y_ff;
   logic signed [23:0]           prev_x_ff;
   logic signed [23:0]           prev_y_ff;

   logic [cco_pkg::CAP_W-1:0]    cap_idx;
   logic [cco_pkg::CAP_W-1:0]    d;
   logic                         on_cap2;
   logic [8:0]                   rem_sh;
   logic                         ge;
   logic [31:0]                  ang;
   logic [31:0]                  ru;
   logic [1:0]                   quad;
   logic signed [33:0]           cs;
   logic signed [33:0]           sn;
   logic signed [57:0]           rx;
   logic signed [57:0]           ry;
   logic signed [26:0]           sx;
   logic signed [26:0]           sy;
   logic                         advance;
   logic                         last_pt;

   // Point index within its cap and the divider step.
   always_comb begin
      on_cap2 = (k_ff < {1'b0, job_item.cap});
      cap_idx = on_cap2 ? k_ff[cco_pkg::CAP_W-1:0]
                        : cco_pkg::CAP_W'(k_ff - {1'b0, job_item.cap});
      d = job_item.cap - 1'b1;
      rem_sh = {rem_ff[7:0], num_ff[39]};
      ge = (rem_sh >= {1'b0, den_ff});
   end

   // Angle of the current point and its quadrant reduction.
   always_comb begin
      if (job_item.circle) begin
         ang = quo_ff;
      end else if (on_cap2) begin
         ang = job_item.axis - 32'h40000000 + quo_ff;
      end else begin
         ang = job_item.axis + 32'h40000000 + quo_ff;
      end
      quad = 2'((ang + 32'h20000000) >> 30);
      ru = ang - {quad, 30'b0};
   end

   // Quadrant correction of the rotated vector.
   always_comb begin
      case (quad_ff)
         2'd1: begin
            cs = -y_ff;
            sn = x_ff;
         end
         2'd2: begin
            cs = -x_ff;
            sn = -y_ff;
         end
         2'd3: begin
            cs = y_ff;
            sn = -x_ff;
         end
         default: begin
            cs = x_ff;
            sn = y_ff;
         end
      endcase
   end

   // Rounding, centre offset and saturation of the point.
   always_comb begin
      rx = (prod_x_ff + HALF) >>> 30;
      ry = (prod_y_ff + HALF) >>> 30;
      sx = 27'(cx_ff) + $signed(rx[26:0]);
      sy = 27'(cy_ff) + $signed(ry[26:0]);
   end

   assign advance = (k_ff == '0) || !seg_full;
   assign last_pt = ((k_ff + 1'b1) == job_item.count) || ((k_ff + 1'b1) == MAXP);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cco_pkg::B_IDLE: begin
            if (!job_empty) state_in = cco_pkg::B_SETUP;
         end
         cco_pkg::B_SETUP: state_in = cco_pkg::B_DIV;
         cco_pkg::B_DIV: begin
            if (step_ff == 6'(DIV_STEPS - 1)) state_in = cco_pkg::B_RINIT;
         end
         cco_pkg::B_RINIT: state_in = cco_pkg::B_ROT;
         cco_pkg::B_ROT: begin
            if (it_ff == 5'(ITERS_EFF - 1)) state_in = cco_pkg::B_MUL;
         end
         cco_pkg::B_MUL: state_in = cco_pkg::B_SUM;
         cco_pkg::B_SUM: state_in = cco_pkg::B_POINT;
         cco_pkg::B_POINT: begin
            if (closing_ff) begin
               if (!seg_full) state_in = cco_pkg::B_IDLE;
            end else if (advance && !last_pt) begin
               state_in = cco_pkg::B_SETUP;
            end
         end
         default: state_in = cco_pkg::B_IDLE;
      endcase
   end

   // Outputs: the closing segment wraps back to the first point.
   always_comb begin
      seg_push = (state_ff == cco_pkg::B_POINT) && !seg_full && (closing_ff || k_ff != '0);
      job_pop = (state_ff == cco_pkg::B_POINT) && closing_ff && !seg_full;
      seg_item.from_x = prev_x_ff;
      seg_item.from_y = prev_y_ff;
      seg_item.to_x = closing_ff ? first_x_ff : px_ff;
      seg_item.to_y = closing_ff ? first_y_ff : py_ff;
      seg_item.last = closing_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cco_pkg::B_IDLE;
         k_ff <= '0;
         closing_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == cco_pkg::B_POINT) begin
            if (closing_ff) begin
               if (!seg_full) begin
                  closing_ff <= 1'b0;
                  k_ff <= '0;
               end
            end else if (advance) begin
               if (last_pt) closing_ff <= 1'b1;
               else k_ff <= k_ff + 1'b1;
            end
         end
      end
   end

   // Point datapath: divider, rotation CORDIC, multiply, round.
   always_ff @(posedge clock) begin
      case (state_ff)
         cco_pkg::B_SETUP: begin
            if (job_item.circle) begin
               num_ff <= {k_ff, 33'b0} + 40'(job_item.count);
               den_ff <= {job_item.count, 1'b0};
            end else begin
               num_ff <= {2'b0, cap_idx, 32'b0} + 40'(d);
               den_ff <= {1'b0, d, 1'b0};
            end
            rem_ff <= '0;
            quo_ff <= '0;
            step_ff <= '0;
         end
         cco_pkg::B_DIV: begin
            rem_ff <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
            num_ff <= {num_ff[38:0], 1'b0};
            quo_ff <= {quo_ff[30:0], ge};
            step_ff <= step_ff + 1'b1;
         end
         cco_pkg::B_RINIT: begin
            x_ff <= $signed(K_Q30[33:0]);
            y_ff <= '0;
            z_ff <= 34'($signed(ru));
            quad_ff <= quad;
            it_ff <= '0;
            cx_ff <= (job_item.circle || !on_cap2) ? job_item.c1x : job_item.c2x;
            cy_ff <= (job_item.circle || !on_cap2) ? job_item.c1y : job_item.c2y;
         end
         cco_pkg::B_ROT: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - (y_ff >>> it_ff);
               y_ff <= y_ff + (x_ff >>> it_ff);
               z_ff <= z_ff - $signed({2'b0, cco_pkg::atan_at(it_ff)});
            end else begin
               x_ff <= x_ff + (y_ff >>> it_ff);
               y_ff <= y_ff - (x_ff >>> it_ff);
               z_ff <= z_ff + $signed({2'b0, cco_pkg::atan_at(it_ff)});
            end
            it_ff <= it_ff + 1'b1;
         end
         cco_pkg::B_MUL: begin
            prod_x_ff <= $signed({1'b0, job_item.radius}) * cs;
            prod_y_ff <= $signed({1'b0, job_item.radius}) * sn;
         end
         cco_pkg::B_SUM: begin
            px_ff <= (sx > C_MAX) ? C_MAX[23:0] : ((sx < C_MIN) ? C_MIN[23:0] : sx[23:0]);
            py_ff <= (sy > C_MAX) ? C_MAX[23:0] : ((sy < C_MIN) ? C_MIN[23:0] : sy[23:0]);
         end
         cco_pkg::B_POINT: begin
            if (!closing_ff && advance) begin
               if (k_ff == '0) begin
                  first_x_ff <= px_ff;
                  first_y_ff <= py_ff;
               end
               prev_x_ff <= px_ff;
               prev_y_ff <= py_ff;
            end
         end
         default: ;
      endcase
   end

endmodule
